### hw/rtl/lep_pkg.sv
// Shared constants, ALU operation codes and character helpers for the line parser.
`timescale 1ns / 1ps
`default_nettype none

package lep_pkg;

    localparam int LINE_DEPTH_DEF = 16;
    localparam int CHAR_W         = 7;
    localparam int VALUE_W        = 16;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
    localparam logic [CHAR_W-1:0] CH_BS    = 7'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 7'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 7'h41;
    localparam logic [CHAR_W-1:0] CH_UH    = 7'h48;
    localparam logic [CHAR_W-1:0] CH_UX    = 7'h58;
    localparam logic [CHAR_W-1:0] CH_UZ    = 7'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LH    = 7'h68;
    localparam logic [CHAR_W-1:0] CH_LX    = 7'h78;
    localparam logic [CHAR_W-1:0] CH_LZ    = 7'h7A;

    // Shared arithmetic unit operations
    typedef enum logic [1:0] {
        ALU_MAC10,
        ALU_SHL4,
        ALU_NEG
    } alu_op_t;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Digit weight in hex mode; any letter counts by case, other characters wrap as code minus '0'
    function automatic logic [VALUE_W-1:0] hex_digit(input logic [CHAR_W-1:0] c);
        logic [VALUE_W-1:0] wide;
        wide = {{(VALUE_W-CHAR_W){1'b0}}, c};
        if ((c >= CH_UA) && (c <= CH_UZ)) begin
            return wide - 16'd55;
        end else if ((c >= CH_LA) && (c <= CH_LZ)) begin
            return wide - 16'd87;
        end else begin
            return wide - 16'd48;
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/lep_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lep_ram #(
    parameter int WIDTH  = 7,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write on request, read every cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/lep_alu.sv
// Shared 16-bit arithmetic unit: decimal accumulate, hex shift-in and negate.
`timescale 1ns / 1ps
`default_nettype none

module lep_alu
    import lep_pkg::*;
(
    input  wire alu_op_t            op,
    input  wire logic [VALUE_W-1:0] acc,
    input  wire logic [VALUE_W-1:0] digit,
    output logic      [VALUE_W-1:0] result
);

    // All results wrap modulo 2^16
    always_comb begin
        case (op)
            ALU_MAC10: result = (acc << 3) + (acc << 1) + digit;
            ALU_SHL4:  result = (acc << 4) + digit;
            ALU_NEG:   result = 16'd0 - acc;
            default:   result = acc;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/line_edit_integer_parser_top.sv
// Top level of the line-editing integer parser: line store, sequencer and output register.
//
//  Channel  | Dir | Handshake          | Payload
//  ---------+-----+--------------------+--------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tdata[6:0] rx_char
//  m_       | out | m_tvalid/m_tready  | m_tdata[15:0] value, m_tdata[16] empty_line
//
// An ordinary character or backspace is taken without a stall. After a carriage return
// s_tready stays low while the single read port of the line store is walked once to
// find length, sign and prefix, then again over the characters left after sign and
// prefix to feed the shared ALU, with an optional negation step at the end.
// aresetn is synchronous; it empties the line and drops any pending result.
// s_tready is low while a line is parsed and while a result waits behind a full
// output register; m_tdata holds steady while m_tvalid is stalled.
`timescale 1ns / 1ps
`default_nettype none

module line_edit_integer_parser_top
    import lep_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [6:0] rx_char, [7] unused
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata    // [15:0] value, [16] empty_line, [23:17] zero
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SETUP,
        ST_PARSE,
        ST_FIX,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DEC_BLANK,
        DEC_DIGIT,
        DEC_STOP
    } dec_phase_t;

    state_t              state_reg,   state_next;
    dec_phase_t          phase_reg,   phase_next;
    logic [CW-1:0]       fill_reg,    fill_next;
    logic [CW-1:0]       idx_reg,     idx_next;
    logic [CW-1:0]       end_reg,     end_next;
    logic [CW-1:0]       len_reg,     len_next;
    logic [CW-1:0]       rd_idx_reg,  rd_idx_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                nul_reg,     nul_next;
    logic [CHAR_W-1:0]   c0_reg,      c0_next;
    logic [CHAR_W-1:0]   c1_reg,      c1_next;
    logic [CHAR_W-1:0]   c2_reg,      c2_next;
    logic [CHAR_W-1:0]   last_reg,    last_next;
    logic                minus_reg,   minus_next;
    logic                hex_reg,     hex_next;
    logic                dec_neg_reg, dec_neg_next;
    logic                empty_reg,   empty_next;
    logic [VALUE_W-1:0]  acc_reg,     acc_next;
    logic                m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]  m_value_reg, m_value_next;
    logic                m_empty_reg, m_empty_next;

    logic                s_acc;
    logic [CHAR_W-1:0]   rx_char;
    logic                wr_en;
    logic                issue;
    logic [CHAR_W-1:0]   rd_char;
    alu_op_t             alu_op;
    logic [VALUE_W-1:0]  alu_digit;
    logic [VALUE_W-1:0]  alu_result;

    // Setup decode
    logic                p_minus;
    logic [CHAR_W-1:0]   ch_p;
    logic [CHAR_W-1:0]   ch_p1;
    logic                pfx;
    logic [1:0]          pos2;
    logic [CW-1:0]       pos;
    logic                trail_h;

    assign rx_char  = s_tdata[CHAR_W-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign wr_en    = s_acc && (rx_char != CH_CR) && (rx_char != CH_BS) &&
                      (fill_reg < CW'(LINE_DEPTH));

    assign issue = ((state_reg == ST_SCAN) && (idx_reg < fill_reg) && !nul_reg) ||
                   ((state_reg == ST_PARSE) && (idx_reg < end_reg));

    lep_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_DEPTH),
        .ADDR_W(AW)
    ) u_lep_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(fill_reg[AW-1:0]),
        .wr_data(rx_char),
        .rd_addr(idx_reg[AW-1:0]),
        .rd_data(rd_char)
    );

    // Pick the ALU operation for the current step
    always_comb begin
        if (state_reg == ST_FIX) begin
            alu_op = ALU_NEG;
        end else if (hex_reg) begin
            alu_op = ALU_SHL4;
        end else begin
            alu_op = ALU_MAC10;
        end
        alu_digit = hex_reg ? hex_digit(rd_char)
                            : ({{(VALUE_W-CHAR_W){1'b0}}, rd_char} - 16'd48);
    end

    lep_alu u_lep_alu (
        .op    (alu_op),
        .acc   (acc_reg),
        .digit (alu_digit),
        .result(alu_result)
    );

    // Decode sign, prefix and trailing hex marker from the first pass
    always_comb begin
        p_minus = (len_reg != '0) && (c0_reg == CH_MINUS);
        ch_p    = p_minus ? c1_reg : c0_reg;
        ch_p1   = p_minus ? c2_reg : c1_reg;
        pfx     = (p_minus ? (len_reg > CW'(2)) : (len_reg > CW'(1))) &&
                  (ch_p == CH_ZERO) && ((ch_p1 == CH_LX) || (ch_p1 == CH_UX));
        pos2    = {pfx, p_minus};
        pos     = CW'(pos2);
        trail_h = (last_reg == CH_LH) || (last_reg == CH_UH);
    end

    // Sequencer next-state logic
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        end_next      = end_reg;
        len_next      = len_reg;
        rd_idx_next   = idx_reg;
        rd_valid_next = issue;
        nul_next      = nul_reg;
        c0_next       = c0_reg;
        c1_next       = c1_reg;
        c2_next       = c2_reg;
        last_next     = last_reg;
        minus_next    = minus_reg;
        hex_next      = hex_reg;
        dec_neg_next  = dec_neg_reg;
        empty_next    = empty_reg;
        acc_next      = acc_reg;
        m_value_next  = m_value_reg;
        m_empty_next  = m_empty_reg;
        m_valid_next  = m_valid_reg && !m_tready;

        if (issue) begin
            idx_next = idx_reg + CW'(1);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (rx_char == CH_CR) begin
                        idx_next   = '0;
                        len_next   = '0;
                        nul_next   = 1'b0;
                        state_next = ST_SCAN;
                    end else if (rx_char == CH_BS) begin
                        if (fill_reg != '0) begin
                            fill_next = fill_reg - CW'(1);
                        end
                    end else if (wr_en) begin
                        fill_next = fill_reg + CW'(1);
                    end
                end
            end
            ST_SCAN: begin
                // Find the text length and keep the head and tail characters
                if (rd_valid_reg && !nul_reg) begin
                    if (rd_char == CH_NUL) begin
                        nul_next = 1'b1;
                    end else begin
                        len_next  = rd_idx_reg + CW'(1);
                        last_next = rd_char;
                        if (rd_idx_reg == CW'(0)) begin
                            c0_next = rd_char;
                        end
                        if (rd_idx_reg == CW'(1)) begin
                            c1_next = rd_char;
                        end
                        if (rd_idx_reg == CW'(2)) begin
                            c2_next = rd_char;
                        end
                    end
                end
                if (!issue && !rd_valid_reg) begin
                    fill_next  = '0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                minus_next = p_minus;
                if (len_reg <= pos) begin
                    empty_next = 1'b1;
                    acc_next   = '1;
                    state_next = ST_OUT;
                end else begin
                    empty_next   = 1'b0;
                    hex_next     = pfx || trail_h;
                    idx_next     = pos;
                    end_next     = trail_h ? (len_reg - CW'(1)) : len_reg;
                    acc_next     = '0;
                    dec_neg_next = 1'b0;
                    phase_next   = DEC_BLANK;
                    state_next   = ST_PARSE;
                end
            end
            ST_PARSE: begin
                // Feed each returned character through the shared ALU
                if (rd_valid_reg) begin
                    if (hex_reg) begin
                        acc_next = alu_result;
                    end else begin
                        case (phase_reg)
                            DEC_BLANK: begin
                                if (is_blank(rd_char)) begin
                                    phase_next = DEC_BLANK;
                                end else if ((rd_char == CH_PLUS) ||
                                             (rd_char == CH_MINUS)) begin
                                    dec_neg_next = (rd_char == CH_MINUS);
                                    phase_next   = DEC_DIGIT;
                                end else if (is_digit(rd_char)) begin
                                    acc_next   = alu_result;
                                    phase_next = DEC_DIGIT;
                                end else begin
                                    phase_next = DEC_STOP;
                                end
                            end
                            DEC_DIGIT: begin
                                if (is_digit(rd_char)) begin
                                    acc_next = alu_result;
                                end else begin
                                    phase_next = DEC_STOP;
                                end
                            end
                            default: begin
                                phase_next = DEC_STOP;
                            end
                        endcase
                    end
                end
                if (!issue && !rd_valid_reg) begin
                    state_next = (minus_reg ^ dec_neg_reg) ? ST_FIX : ST_OUT;
                end
            end
            ST_FIX: begin
                acc_next   = alu_result;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Load the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_value_next = acc_reg;
                    m_empty_next = empty_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            rd_valid_reg <= 1'b0;
            nul_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            rd_valid_reg <= rd_valid_next;
            nul_reg      <= nul_next;
            m_valid_reg  <= m_valid_next;
        end
        phase_reg   <= phase_next;
        idx_reg     <= idx_next;
        end_reg     <= end_next;
        len_reg     <= len_next;
        rd_idx_reg  <= rd_idx_next;
        c0_reg      <= c0_next;
        c1_reg      <= c1_next;
        c2_reg      <= c2_next;
        last_reg    <= last_next;
        minus_reg   <= minus_next;
        hex_reg     <= hex_next;
        dec_neg_reg <= dec_neg_next;
        empty_reg   <= empty_next;
        acc_reg     <= acc_next;
        m_value_reg <= m_value_next;
        m_empty_reg <= m_empty_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_empty_reg, m_value_reg};

endmodule

`default_nettype wire

### hw/rtl/lep_checker.sv
// Port-level assertions for the line parser top level, attached by bind.
`timescale 1ns / 1ps
`default_nettype none

module lep_checker
    import lep_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A carriage return starts a parse, so input stalls next cycle
    a_cr_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tdata[6:0] == CH_CR)) |=> !s_tready)
        else $error("input ready right after end of line");

    // Only a carriage return may raise a result
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tdata[6:0] != CH_CR) && !m_tvalid) |=> !m_tvalid)
        else $error("result without end of line");

    // An empty line always reports minus one
    a_empty_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[16]) |-> (m_tdata[15:0] == 16'hFFFF))
        else $error("empty line with value other than -1");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind line_edit_integer_parser_top lep_checker u_lep_checker (.*);

`default_nettype wire

### bench/line_edit_integer_parser_top_tb.sv
// Self-checking testbench for the line-editing integer parser: typed lines in, parsed values out.
`timescale 1ns / 1ps

module line_edit_integer_parser_top_tb;

    localparam int LINE_CAP    = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 2000;
    localparam int TAIL_CYCLES = 60;
    localparam int QUIET_TAIL  = 120;
    localparam int RANDOM_KEYS = 850;

    // Character codes
    localparam logic [6:0] ASC_NUL   = 7'h00;
    localparam logic [6:0] ASC_BS    = 7'h08;
    localparam logic [6:0] ASC_TAB   = 7'h09;
    localparam logic [6:0] ASC_FF    = 7'h0C;
    localparam logic [6:0] ASC_CR    = 7'h0D;
    localparam logic [6:0] ASC_SPACE = 7'h20;
    localparam logic [6:0] ASC_PLUS  = 7'h2B;
    localparam logic [6:0] ASC_MINUS = 7'h2D;
    localparam logic [6:0] ASC_ZERO  = 7'h30;
    localparam logic [6:0] ASC_NINE  = 7'h39;
    localparam logic [6:0] ASC_UA    = 7'h41;
    localparam logic [6:0] ASC_UH    = 7'h48;
    localparam logic [6:0] ASC_UX    = 7'h58;
    localparam logic [6:0] ASC_UZ    = 7'h5A;
    localparam logic [6:0] ASC_LA    = 7'h61;
    localparam logic [6:0] ASC_LH    = 7'h68;
    localparam logic [6:0] ASC_LX    = 7'h78;
    localparam logic [6:0] ASC_LZ    = 7'h7A;
    localparam logic [6:0] ASC_TILDE = 7'h7E;
    localparam logic [6:0] ASC_DEL   = 7'h7F;

    typedef struct packed {
        logic        empty_line;
        logic [15:0] value;
    } parse_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [6:0] rx_char, [7] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [15:0] value, [16] empty_line, [23:17] zero

    // Keystrokes waiting to be sent and parse results waiting to come out
    logic [6:0]    keystroke_q[$];
    parse_result_t parsed_q[$];

    // Shadow copy of the edited line
    logic [6:0]  line_buf [LINE_CAP];
    int unsigned line_cnt = 0;

    logic          s_hs      = 1'b0;
    int            s_gap     = 0;
    int            m_stall   = 0;
    int            err_cnt   = 0;
    int            cycle_cnt = 0;
    parse_result_t want_res;

    line_edit_integer_parser_top #(
        .LINE_DEPTH(LINE_CAP)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Parse the shadow line the way the block must on carriage return
    function automatic parse_result_t parse_line_buf();
        parse_result_t res;
        int unsigned   len, pos, stop, k;
        logic          minus, hex, dec_neg;
        logic [15:0]   acc, wide;
        logic [6:0]    c;
        len     = 0;
        pos     = 0;
        minus   = 1'b0;
        hex     = 1'b0;
        dec_neg = 1'b0;
        acc     = '0;
        // the text stops at the first stored NUL
        while (len < line_cnt && line_buf[len] != ASC_NUL) len++;
        if (len > 0 && line_buf[0] == ASC_MINUS) begin
            minus = 1'b1;
            pos   = 1;
        end
        if (pos + 1 < len && line_buf[pos] == ASC_ZERO &&
            (line_buf[pos+1] == ASC_LX || line_buf[pos+1] == ASC_UX)) begin
            hex = 1'b1;
            pos += 2;
        end
        stop = len;
        if (stop <= pos) begin
            res.value      = 16'hFFFF;
            res.empty_line = 1'b1;
            return res;
        end
        // trailing h forces hex
        if (line_buf[stop-1] == ASC_LH || line_buf[stop-1] == ASC_UH) begin
            hex = 1'b1;
            stop--;
        end
        if (hex) begin
            // unchecked digits: letters by case, everything else as code minus '0'
            for (k = pos; k < stop; k++) begin
                c    = line_buf[k];
                wide = {9'b0, c};
                if (c >= ASC_UA && c <= ASC_UZ)
                    wide = wide - {9'b0, ASC_UA} + 16'd10;
                else if (c >= ASC_LA && c <= ASC_LZ)
                    wide = wide - {9'b0, ASC_LA} + 16'd10;
                else
                    wide = wide - {9'b0, ASC_ZERO};
                acc = {acc[11:0], 4'h0} + wide;
            end
        end else begin
            // skip leading white space, take one sign, then digits
            while (pos < stop && (line_buf[pos] == ASC_SPACE ||
                   (line_buf[pos] >= ASC_TAB && line_buf[pos] <= ASC_CR)))
                pos++;
            if (pos < stop && (line_buf[pos] == ASC_PLUS || line_buf[pos] == ASC_MINUS)) begin
                dec_neg = (line_buf[pos] == ASC_MINUS);
                pos++;
            end
            while (pos < stop && line_buf[pos] >= ASC_ZERO && line_buf[pos] <= ASC_NINE) begin
                acc = acc * 16'd10 + {9'b0, line_buf[pos] - ASC_ZERO};
                pos++;
            end
            if (dec_neg) acc = -acc;
        end
        if (minus) acc = -acc;
        res.value      = acc;
        res.empty_line = 1'b0;
        return res;
    endfunction

    // Apply one accepted keystroke to the shadow line
    task automatic take_keystroke(input logic [6:0] c);
        if (c == ASC_CR) begin
            parsed_q.push_back(parse_line_buf());
            line_cnt = 0;
        end else if (c == ASC_BS) begin
            if (line_cnt > 0) line_cnt--;
        end else if (line_cnt < LINE_CAP) begin
            line_buf[line_cnt] = c;
            line_cnt++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        err_cnt++;
        $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
    endtask

    // Queue a character, now and then after a typo that gets erased
    task automatic put_char(input logic [6:0] c);
        if ($urandom_range(0, 15) == 0) begin
            keystroke_q.push_back(7'($urandom_range(ASC_SPACE, ASC_TILDE)));
            keystroke_q.push_back(ASC_BS);
        end
        keystroke_q.push_back(c);
    endtask

    task automatic push_text(input string s);
        byte b;
        for (int k = 0; k < s.len(); k++) begin
            b = s[k];
            keystroke_q.push_back(b[6:0]);
        end
    endtask

    // Input driver: present items, with random gaps between them
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_hs) begin
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (keystroke_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                s_gap = $urandom_range(1, 17) - 1;
                s_tvalid <= 1'b0;
            end else if (keystroke_q.size() != 0) begin
                s_tdata  <= {1'b0, keystroke_q.pop_front()};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result backpressure in random bursts
    always @(negedge aclk) begin
        if (m_stall > 0) begin
            m_stall--;
            m_tready <= 1'b0;
        end else if (keystroke_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            m_stall = $urandom_range(1, 17) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: check results, then track accepted keystrokes
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_hs <= 1'b0;
        end else begin
            s_hs <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (parsed_q.size() == 0) begin
                    report_mismatch("result with none expected", m_tdata, 24'h0);
                end else begin
                    want_res = parsed_q.pop_front();
                    if (m_tdata[15:0] !== want_res.value)
                        report_mismatch("value", 24'(m_tdata[15:0]), 24'(want_res.value));
                    if (m_tdata[16] !== want_res.empty_line)
                        report_mismatch("empty_line", 24'(m_tdata[16]),
                                        24'(want_res.empty_line));
                    if (m_tdata[23:17] !== 7'h00)
                        report_mismatch("tdata padding", 24'(m_tdata[23:17]), 24'h0);
                end
            end
            if (s_tvalid && s_tready) take_keystroke(s_tdata[6:0]);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("line_edit_integer_parser_top_tb NOT OK");
            $finish;
        end
    end

    initial begin
        int         kind, n, k, drain, goal;
        logic [6:0] c;
        string      hex_set;
        hex_set = "0123456789abcdefABCDEF";

        // Directed lines: empty, backspace on empty, bare sign and prefix, lone h,
        // double sign, prefixed hex, stored NUL, all-ones code, blanks with plus
        keystroke_q.push_back(ASC_CR);
        keystroke_q.push_back(ASC_BS);
        push_text("-");
        keystroke_q.push_back(ASC_CR);
        push_text("0x");
        keystroke_q.push_back(ASC_CR);
        push_text("h");
        keystroke_q.push_back(ASC_CR);
        push_text("--5");
        keystroke_q.push_back(ASC_CR);
        push_text("0xfA");
        keystroke_q.push_back(ASC_CR);
        push_text("1");
        keystroke_q.push_back(ASC_NUL);
        push_text("2");
        keystroke_q.push_back(ASC_CR);
        keystroke_q.push_back(ASC_DEL);
        keystroke_q.push_back(ASC_CR);
        push_text(" +9");
        keystroke_q.push_back(ASC_CR);

        // Random lines, mostly well formed
        goal = keystroke_q.size() + RANDOM_KEYS;
        while (keystroke_q.size() < goal) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: begin
                    // decimal, up to six digits so that it overflows at times
                    n = $urandom_range(0, 2);
                    for (k = 0; k < n; k++) begin
                        if ($urandom_range(0, 4) == 0) put_char(ASC_SPACE);
                        else put_char(7'($urandom_range(ASC_TAB, ASC_FF)));
                    end
                    n = $urandom_range(0, 3);
                    if (n == 0) put_char(ASC_PLUS);
                    else if (n == 1) put_char(ASC_MINUS);
                    n = $urandom_range(1, 6);
                    for (k = 0; k < n; k++) put_char(ASC_ZERO + 7'($urandom_range(0, 9)));
                    if ($urandom_range(0, 3) == 0)
                        put_char(7'($urandom_range(ASC_SPACE, ASC_TILDE)));
                end
                3, 4: begin
                    // prefixed hex
                    if ($urandom_range(0, 2) == 0) put_char(ASC_MINUS);
                    put_char(ASC_ZERO);
                    put_char($urandom_range(0, 1) ? ASC_LX : ASC_UX);
                    n = $urandom_range(1, 5);
                    for (k = 0; k < n; k++) put_char(7'(hex_set[$urandom_range(0, 21)]));
                    if ($urandom_range(0, 3) == 0) put_char(ASC_LH);
                end
                5: begin
                    // hex marked by a trailing h
                    if ($urandom_range(0, 2) == 0) put_char(ASC_MINUS);
                    n = $urandom_range(1, 4);
                    for (k = 0; k < n; k++) put_char(7'(hex_set[$urandom_range(0, 21)]));
                    put_char($urandom_range(0, 1) ? ASC_LH : ASC_UH);
                end
                6: begin
                    // long line that may overrun the store
                    n = $urandom_range(14, 22);
                    for (k = 0; k < n; k++) begin
                        if ($urandom_range(0, 9) < 7) c = ASC_ZERO + 7'($urandom_range(0, 9));
                        else c = 7'($urandom_range(ASC_SPACE, ASC_TILDE));
                        put_char(c);
                    end
                end
                7: begin
                    // raw noise over the whole code space
                    n = $urandom_range(0, 8);
                    for (k = 0; k < n; k++) keystroke_q.push_back(7'($urandom_range(0, 127)));
                end
                default: begin
                    // sign and prefix corners
                    case ($urandom_range(0, 4))
                        0: put_char(ASC_MINUS);
                        1: begin
                            put_char(ASC_MINUS);
                            put_char(ASC_ZERO);
                            put_char(ASC_LX);
                        end
                        2: begin
                            put_char(ASC_ZERO);
                            put_char(ASC_UX);
                        end
                        3: begin
                            put_char(ASC_MINUS);
                            put_char(ASC_MINUS);
                            n = $urandom_range(1, 5);
                            for (k = 0; k < n; k++)
                                put_char(ASC_ZERO + 7'($urandom_range(0, 9)));
                        end
                        default: begin
                            put_char(ASC_MINUS);
                            put_char($urandom_range(0, 1) ? ASC_LH : ASC_UH);
                        end
                    endcase
                end
            endcase
            keystroke_q.push_back(ASC_CR);
        end

        // Hold reset, then release on a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for the last item to go in, then for the results to drain
        while (keystroke_q.size() != 0 || s_tvalid) @(posedge aclk);
        drain = 0;
        while (parsed_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (parsed_q.size() != 0)
            report_mismatch("results never delivered", 24'(parsed_q.size()), 24'h0);

        if (err_cnt == 0) begin
            $display("line_edit_integer_parser_top_tb OK");
        end else begin
            $display("line_edit_integer_parser_top_tb NOT OK");
        end
        $finish;
    end

endmodule
